/* sv/rrbp_pkg.sv */
// Shared field widths, request and status codes, and the stage-one record of the buffer pool.
package rrbp_pkg;

	localparam int ID_W   = 6;
	localparam int QSEL_W = 3;
	localparam int ID_N   = 1 << ID_W;

	localparam logic REQ_TAKE   = 1'b0;
	localparam logic REQ_RETURN = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic              grant;
		status_t           status;
		logic [QSEL_W-1:0] queue;
		logic [ID_W-1:0]   base_id;
		logic              use_ram;
		logic [ID_W-1:0]   init_slot;
	} rrbp_s1_t;

endpackage

/* sv/rrbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rrbp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/rrbp_qctl.sv */
// Queue pointers, fill counts and round-robin select; issues the store access for each beat.
module rrbp_qctl #(
	parameter int NUM_QUEUES      = 8,
	parameter int SLOTS_PER_QUEUE = 8,
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
	localparam int SW = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1,
	localparam int FW = $clog2(SLOTS_PER_QUEUE + 1),
	localparam int AW = (NUM_QUEUES * SLOTS_PER_QUEUE > 1) ?
		$clog2(NUM_QUEUES * SLOTS_PER_QUEUE) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     acc,
	input  logic                     req_type,
	input  logic [rrbp_pkg::ID_W-1:0] buffer_id,
	output logic                     wr_en,
	output logic [AW-1:0]            wr_addr,
	output logic [SW-1:0]            wr_data,
	output logic [AW-1:0]            rd_addr,
	output rrbp_pkg::rrbp_s1_t       stage_s1
);
	import rrbp_pkg::*;

	localparam int TW = SW + 1;

	logic [QW-1:0]   rr_q;
	logic [SW-1:0]   head_q  [NUM_QUEUES];
	logic [FW-1:0]   fill_q  [NUM_QUEUES];
	logic [FW-1:0]   wmark_q [NUM_QUEUES];

	logic [ID_W-1:0] home_lut [ID_N];
	logic [SW-1:0]   slot_lut [ID_N];

	logic            is_take;
	logic [ID_W-1:0] home;
	logic [SW-1:0]   slot_in;
	logic            home_ok;
	logic [QW-1:0]   q;
	logic [SW-1:0]   h;
	logic [FW-1:0]   f;
	logic [FW-1:0]   wm;
	logic            take_ok;
	logic            ret_ok;
	logic [TW-1:0]   tail_sum;
	logic [SW-1:0]   tail;
	logic [SW-1:0]   h_next;
	logic [AW-1:0]   qbase;

	for (genvar i = 0; i < ID_N; i++) begin : g_lut
		assign home_lut[i] = ID_W'(i / SLOTS_PER_QUEUE);
		assign slot_lut[i] = SW'(i % SLOTS_PER_QUEUE);
	end

	always_comb begin
		is_take  = (req_type == REQ_TAKE);
		home     = home_lut[buffer_id];
		slot_in  = slot_lut[buffer_id];
		home_ok  = ({1'b0, home} < (ID_W + 1)'(NUM_QUEUES));
		q        = is_take ? rr_q : home[QW-1:0];
		h        = head_q[q];
		f        = fill_q[q];
		wm       = wmark_q[q];
		take_ok  = is_take && (f != '0);
		ret_ok   = !is_take && home_ok && (f != FW'(SLOTS_PER_QUEUE));
		tail_sum = TW'(h) + TW'(f);
		tail     = (tail_sum >= TW'(SLOTS_PER_QUEUE)) ?
			SW'(tail_sum - TW'(SLOTS_PER_QUEUE)) : SW'(tail_sum);
		h_next   = (h == SW'(SLOTS_PER_QUEUE - 1)) ? '0 : SW'(h + 1'b1);
		qbase    = AW'(q) * AW'(SLOTS_PER_QUEUE);
		rd_addr  = qbase + AW'(h);
		wr_addr  = qbase + AW'(tail);
		wr_data  = slot_in;
		wr_en    = acc && ret_ok;
	end

	// Positions below the write mark hold stored slots; above it a queue still has its reset order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= '0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				fill_q[i]  <= FW'(SLOTS_PER_QUEUE);
				wmark_q[i] <= '0;
			end
		end else if (acc) begin
			if (is_take) begin
				rr_q <= (rr_q == QW'(NUM_QUEUES - 1)) ? '0 : QW'(rr_q + 1'b1);
			end
			if (take_ok) begin
				head_q[q] <= h_next;
				fill_q[q] <= FW'(f - 1'b1);
			end
			if (ret_ok) begin
				fill_q[q] <= FW'(f + 1'b1);
				if (wm != FW'(SLOTS_PER_QUEUE)) begin
					wmark_q[q] <= FW'(wm + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1.valid     <= acc;
			stage_s1.grant     <= take_ok;
			stage_s1.status    <= is_take ? (take_ok ? ST_OK : ST_EMPTY) :
				(ret_ok ? ST_OK : ST_FULL);
			stage_s1.queue     <= is_take ? QSEL_W'(rr_q) : home[QSEL_W-1:0];
			stage_s1.base_id   <= ID_W'(qbase);
			stage_s1.use_ram   <= (FW'(h) < wm);
			stage_s1.init_slot <= ID_W'(h);
		end
	end

endmodule

/* sv/round_robin_buffer_pool_core.sv */
// Top level of the round-robin buffer pool: queue control, slot store and result register.
//
// Usage:
//   Request channel: drive req_type and buffer_id with start high; a beat is
//   accepted at every rising edge where start is high and busy is low. busy
//   stays low, so one request can be accepted on every clock.
//   A take (req_type 0) pops the oldest slot of the queue named by the
//   round-robin pointer, which advances on every take; a return (req_type 1)
//   appends the slot of buffer_id to its home queue.
//   Result channel: done pulses for exactly one cycle, once the request beat
//   has passed the stage-one and result registers, with granted_id, status and
//   queue_chosen. Results leave in request order, one per request; the
//   receiver has no way to stall them. Throughput is one request per cycle;
//   a result passes the registered read of the slot store and the result register.
//   Reset (arst_n low) makes every queue full with its slots in order, the
//   round-robin pointer zero and clears pending results. The slot store is
//   not swept: a per-queue write mark tells which positions still read as
//   their reset order, so no clearing pass is needed after reset.
module round_robin_buffer_pool_core #(
	parameter int NUM_QUEUES      = 8,
	parameter int SLOTS_PER_QUEUE = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        req_type,
	input  logic [rrbp_pkg::ID_W-1:0]   buffer_id,
	output logic                        done,
	output logic [rrbp_pkg::ID_W-1:0]   granted_id,
	output logic [1:0]                  status,
	output logic [rrbp_pkg::QSEL_W-1:0] queue_chosen
);
	import rrbp_pkg::*;

	localparam int SW    = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
	localparam int DEPTH = NUM_QUEUES * SLOTS_PER_QUEUE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic            acc;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [SW-1:0]   wr_data;
	logic [AW-1:0]   rd_addr;
	logic [SW-1:0]   ram_rdata;
	rrbp_s1_t        stage_s1;
	logic [ID_W-1:0] slot_s1;

	logic              done_s2;
	logic [ID_W-1:0]   granted_s2;
	status_t           status_s2;
	logic [QSEL_W-1:0] queue_s2;

	// Every request finishes in one pass, so never hold off the requester.
	assign busy = 1'b0;
	assign acc  = start && !busy;

	rrbp_qctl #(
		.NUM_QUEUES      (NUM_QUEUES),
		.SLOTS_PER_QUEUE (SLOTS_PER_QUEUE)
	) u_qctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.req_type  (req_type),
		.buffer_id (buffer_id),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr   (rd_addr),
		.stage_s1  (stage_s1)
	);

	// Slot store: one entry per buffer position, no reset.
	rrbp_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Pick the stored slot, or the reset order for a position never written.
	assign slot_s1 = stage_s1.use_ram ? ID_W'(ram_rdata) : stage_s1.init_slot;

	// Result register: register each result, drop granted_id to zero unless granted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		granted_s2 <= stage_s1.grant ? ID_W'(stage_s1.base_id + slot_s1) : '0;
		status_s2  <= stage_s1.status;
		queue_s2   <= stage_s1.queue;
	end

	assign done         = done_s2;
	assign granted_id   = granted_s2;
	assign status       = status_s2;
	assign queue_chosen = queue_s2;

`ifndef SYNTH
	a_result_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ##1 done)
		else $error("accepted beat produced no result two cycles later");

	a_grant_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (granted_id != '0)) |-> (status == ST_OK))
		else $error("nonzero granted_id with a failing status");

	a_no_result_without_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(stage_s1.valid))
		else $error("result strobe without a request in stage one");

	a_empty_grants_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_EMPTY)) |-> (granted_id == '0))
		else $error("empty take handed out an identifier");
`endif

endmodule
